// ===== rtl/core/bin_packing_placer_macros.svh =====
`ifndef BIN_PACKING_PLACER_MACROS_SVH
`define BIN_PACKING_PLACER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bpp_pkg.sv =====
`timescale 1ns / 1ps

package bpp_pkg;

   localparam int MAX_BINS  = 16;
   localparam int SIZE_BITS = 8;
   localparam int IDX_W     = $clog2(MAX_BINS);
   localparam int CNT_W     = $clog2(MAX_BINS + 1);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [SIZE_BITS-1:0] CAPACITY_RESET = SIZE_BITS'(10);

   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_POLICY   = 1'b1;

   typedef enum logic [1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_NEXT  = 2'd1,
      POLICY_BEST  = 2'd2,
      POLICY_WORST = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_NO_BIN  = 2'd1,
      STATUS_TOO_BIG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_COMMIT = 2'd2
   } state_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] item_size;
      logic                 start_new_set;
   } req_type;

   typedef struct packed {
      logic [3:0]           bin_index;
      logic                 opened_new;
      logic [SIZE_BITS-1:0] room_left;
      logic [4:0]           bins_in_use;
      status_type           status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

// ===== rtl/core/bpp_ctrl.sv =====
`timescale 1ns / 1ps

module bpp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bpp_pkg::dp_status_type dp_status,
   output bpp_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);

   bpp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpp_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bpp_pkg::ST_SCAN;
            end
         end
         bpp_pkg::ST_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = bpp_pkg::ST_COMMIT;
            end
         end
         bpp_pkg::ST_COMMIT: begin
            state_in = bpp_pkg::ST_IDLE;
         end
         default: begin
            state_in = bpp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         bpp_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         bpp_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         bpp_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/bpp_datapath.sv =====
`timescale 1ns / 1ps

module bpp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bpp_pkg::ctrl_cmd_type               cmd,
   output bpp_pkg::dp_status_type              dp_status,
   input  bpp_pkg::req_type                    req_item,
   input  logic                                csr_we,
   input  logic [bpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpp_pkg::CSR_DAT_W-1:0]       csr_wdata,
   output logic                                rsp_valid,
   output bpp_pkg::rsp_type                    rsp_item
);

   localparam int SW = bpp_pkg::SIZE_BITS;
   localparam int IW = bpp_pkg::IDX_W;
   localparam int CW = bpp_pkg::CNT_W;

   logic [SW-1:0]          cap_ff;
   bpp_pkg::policy_type    policy_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [SW-1:0]          size_ff;
   logic [CW-1:0]          scan_ptr_ff;
   logic                   rd_valid_ff;
   logic [IW-1:0]          rd_idx_ff;
   logic [SW-1:0]          rd_data_ff;
   logic                   found_ff;
   logic [IW-1:0]          chosen_ff;
   logic [SW-1:0]          chosen_room_ff;
   logic                   rsp_valid_ff;
   bpp_pkg::rsp_type       rsp_ff, rsp_in;

   logic [SW-1:0]          mem [bpp_pkg::MAX_BINS];
   logic                   mem_we;
   logic [IW-1:0]          mem_waddr;
   logic [SW-1:0]          mem_wdata;

   logic                   issue;
   logic                   fits;
   logic                   is_last;
   logic                   take;
   logic                   too_big;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= bpp_pkg::CAPACITY_RESET;
         policy_ff <= bpp_pkg::POLICY_FIRST;
      end else if (csr_we) begin
         case (csr_index)
            bpp_pkg::REG_CAPACITY: cap_ff    <= csr_wdata[SW-1:0];
            bpp_pkg::REG_POLICY:   policy_ff <= bpp_pkg::policy_type'(csr_wdata[1:0]);
            default:               cap_ff    <= cap_ff;
         endcase
      end
   end

   // room memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_ptr_ff[IW-1:0]];
   end

   assign issue   = cmd.scan && (scan_ptr_ff < count_ff);
   assign fits    = rd_data_ff >= size_ff;
   assign is_last = {1'b0, rd_idx_ff} == (count_ff - CW'(1));
   assign too_big = size_ff > cap_ff;

   always_comb begin
      case (policy_ff)
         bpp_pkg::POLICY_FIRST: take = fits && !found_ff;
         bpp_pkg::POLICY_NEXT:  take = fits && is_last;
         bpp_pkg::POLICY_BEST:  take = fits && (!found_ff || rd_data_ff < chosen_room_ff);
         bpp_pkg::POLICY_WORST: take = fits && (!found_ff || rd_data_ff > chosen_room_ff);
         default:               take = 1'b0;
      endcase
   end

   assign dp_status.scan_done = (scan_ptr_ff == count_ff) && !rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         scan_ptr_ff <= '0;
      end else if (cmd.load) begin
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         scan_ptr_ff <= '0;
      end else if (cmd.scan) begin
         rd_valid_ff <= issue;
         if (issue) begin
            scan_ptr_ff <= scan_ptr_ff + CW'(1);
         end
         if (rd_valid_ff && take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff <= req_item.item_size;
      end
      if (issue) begin
         rd_idx_ff <= scan_ptr_ff[IW-1:0];
      end
      if (cmd.scan && rd_valid_ff && take) begin
         chosen_ff      <= rd_idx_ff;
         chosen_room_ff <= rd_data_ff;
      end
   end

   // placement decision
   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = bpp_pkg::STATUS_PLACED;
      count_in           = count_ff;
      mem_we             = 1'b0;
      mem_waddr          = chosen_ff;
      mem_wdata          = chosen_room_ff - size_ff;
      if (too_big) begin
         rsp_in.status = bpp_pkg::STATUS_TOO_BIG;
      end else if (found_ff) begin
         mem_we           = cmd.commit;
         rsp_in.bin_index = 4'(chosen_ff);
         rsp_in.room_left = chosen_room_ff - size_ff;
      end else if (count_ff >= CW'(bpp_pkg::MAX_BINS)) begin
         rsp_in.status = bpp_pkg::STATUS_NO_BIN;
      end else begin
         mem_we            = cmd.commit;
         mem_waddr         = count_ff[IW-1:0];
         mem_wdata         = cap_ff - size_ff;
         rsp_in.bin_index  = 4'(count_ff[IW-1:0]);
         rsp_in.opened_new = 1'b1;
         rsp_in.room_left  = cap_ff - size_ff;
         count_in          = count_ff + CW'(1);
      end
      rsp_in.bins_in_use = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.load && req_item.start_new_set) begin
            count_ff <= '0;
         end else if (cmd.commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/core/bin_packing_placer.sv =====
`timescale 1ns / 1ps

// Online bin packer. A transaction is taken when start is high and busy is low; the
// block then reads the room of every open bin, one bin a cycle from its room memory,
// and writes the new room of the chosen or newly opened bin back. The result appears
// on rsp_item for exactly one cycle with rsp_valid high; it is registered after the
// scan and commit states. busy is already low while the result is out, so the next
// transaction can be taken at the edge that ends it.
// The receiver cannot stall, so it must take every result as it comes.
// Configuration (capacity, policy) is written through csr_*; the user must do so only
// while busy is low, as the block itself does not enforce it.

`include "bin_packing_placer_macros.svh"

module bin_packing_placer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bpp_pkg::req_type               req_item,
   output logic                           rsp_valid,
   output bpp_pkg::rsp_type               rsp_item,
   input  logic                           csr_we,
   input  logic [bpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpp_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   bpp_pkg::ctrl_cmd_type  cmd;
   bpp_pkg::dp_status_type dp_status;

   bpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   bpp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_status (dp_status),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `BPP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `BPP_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `BPP_ASSERT_SAME(a_open_placed, clock, reset,
      rsp_valid && rsp_item.opened_new,
      rsp_item.status == bpp_pkg::STATUS_PLACED, "new bin without placement")
   `BPP_ASSERT_SAME(a_placed_count, clock, reset,
      rsp_valid && rsp_item.status == bpp_pkg::STATUS_PLACED,
      rsp_item.bins_in_use != 5'd0, "placed with no open bin")

endmodule
